@@ design/dual_motor_soft_start_pwm_defines.svh @@
// Assertion macros for the dual motor soft start PWM controller.
`ifndef DUAL_MOTOR_SOFT_START_PWM_DEFINES_SVH
`define DUAL_MOTOR_SOFT_START_PWM_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DMSSP_ASSERT_HOLDS(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DMSSP_ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dmssp_pkg.sv @@
// Shared types, widths and codes for the dual motor soft start PWM block.
`default_nettype none

package dmssp_pkg;

    // tick counter width of the soft start timer
    localparam int TICK_COUNT_BITS = 16;

    localparam int SPEED_W  = 16;
    localparam int MAG_W    = 15;
    localparam int DUTY_W   = 16;
    localparam int BITS_W   = 5;
    localparam int SCALE_W  = 9;
    localparam int TICKS_W  = 16;
    localparam int FACTOR_W = 16;
    localparam int PROD_W   = MAG_W + FACTOR_W;
    localparam int TICK_CMP_W = (TICK_COUNT_BITS > TICKS_W) ? TICK_COUNT_BITS : TICKS_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PWM_BITS        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_SCALE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_STEP_TICKS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOTOR_GAP_TICKS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_READY      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_READY     = 3'd5;

    // word kinds
    localparam logic ACTION_CMD  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // |v| < 0.001 and |v| < 0.02 in Q1.15
    localparam logic [MAG_W-1:0] STOP_LIMIT  = 15'd33;
    localparam logic [MAG_W-1:0] START_LIMIT = 15'd656;

    // Q15 ramp factors; unity passes the magnitude through the rounding step
    localparam logic [FACTOR_W-1:0] FACTOR_LOW = 16'd9830;
    localparam logic [FACTOR_W-1:0] FACTOR_MID = 16'd19661;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 16'd32768;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 9'd256;
    localparam logic [BITS_W-1:0]  BITS_MIN  = 5'd1;
    localparam logic [BITS_W-1:0]  BITS_MAX  = 5'd16;

    // operand sources
    localparam logic [2:0] SRC_ITEM_L = 3'd0;
    localparam logic [2:0] SRC_ITEM_R = 3'd1;
    localparam logic [2:0] SRC_HELD_L = 3'd2;
    localparam logic [2:0] SRC_HELD_R = 3'd3;
    localparam logic [2:0] SRC_ZERO   = 3'd4;

    // factor selects
    localparam logic [1:0] FAC_ONE = 2'd0;
    localparam logic [1:0] FAC_LOW = 2'd1;
    localparam logic [1:0] FAC_MID = 2'd2;

    typedef struct packed {
        logic [BITS_W-1:0]  pwm_bits;
        logic [SCALE_W-1:0] output_scale;
        logic [TICKS_W-1:0] ramp_step_ticks;
        logic [TICKS_W-1:0] motor_gap_ticks;
        logic               left_ready;
        logic               right_ready;
    } cfg_t;

    typedef struct packed {
        logic       load_item;
        logic       hold_targets;
        logic       mul_factor;
        logic       mul_scale;
        logic       write_left;
        logic       write_right;
        logic [2:0] src;
        logic [1:0] fac;
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic item_small;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/dual_motor_soft_start_pwm.sv @@
// Top level: configuration registers, controller, datapath and result register.
`default_nettype none

// Dual phase/enable DC motor driver with a tick-timed soft start. Each input word is
// either a speed command (signed Q1.15 left and right speeds) or a one millisecond
// tick, selected by s_axis_tuser. Every input word yields exactly one output word with
// the phase level and enable duty of both channels, plus the running, ramping and
// accepted flags as they stand after that word. Duty is round(|v| * (2^bits-1) *
// scale / 256), half away from zero, capped at full scale; speeds under 0.001 stop a
// channel. Commands with both speeds under 0.02 apply directly and drop the running
// flag; while running or while a channel's ready register is clear, commands apply
// directly; otherwise the left motor ramps through 0.3 and 0.6 of its target to full,
// waits the gap, then the right motor does the same, each step after the programmed
// number of ticks. Commands that arrive during the ramp are dropped and reported with
// accepted low. A channel whose ready register is clear keeps its outputs. Timing: one
// word at a time; a command that drives both channels runs the decide state, then the
// factor, scale and write states for the left and then the right channel, then finish;
// a tick that advances the ramp runs the same states for one channel only; an ignored
// command or a tick with nothing to do goes from decide to finish. The next word is
// taken in the cycle after the result is registered. The single shared multiplier does
// two products (ramp factor, then output scale) per channel in series. The result sits
// in an output register, so the block can take the next word while the previous result
// waits on m_axis_tready; a finished word whose result register is still full and not
// being drained holds the block until it frees up. Configuration writes take effect on
// the next cycle and are meant for idle periods only.

module dual_motor_soft_start_pwm
    import dmssp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] left_speed, [31:16] right_speed
    input  logic [0:0]            s_axis_tuser,   // [0] action (0 command, 1 tick)
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] left_forward, [16:1] left_duty, [17] right_forward, [33:18] right_duty,
    // [34] running, [35] ramping, [36] accepted, [39:37] zero
    output logic [39:0]           m_axis_tdata
);

    cfg_t        cfg_reg;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg;

    dp_cmd_t     dp_cmd;
    dp_status_t  dp_status;
    logic        out_free;
    logic        res_load;
    logic        running, ramping, accepted;
    logic        left_forward, right_forward;
    logic [DUTY_W-1:0] left_duty, right_duty;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_bits        <= 5'd10;
            cfg_reg.output_scale    <= 9'd179;
            cfg_reg.ramp_step_ticks <= 16'd30;
            cfg_reg.motor_gap_ticks <= 16'd60;
            cfg_reg.left_ready      <= 1'b0;
            cfg_reg.right_ready     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PWM_BITS:        cfg_reg.pwm_bits        <= cfg_wdata[BITS_W-1:0];
                CFG_OUTPUT_SCALE:    cfg_reg.output_scale    <= cfg_wdata[SCALE_W-1:0];
                CFG_RAMP_STEP_TICKS: cfg_reg.ramp_step_ticks <= cfg_wdata[TICKS_W-1:0];
                CFG_MOTOR_GAP_TICKS: cfg_reg.motor_gap_ticks <= cfg_wdata[TICKS_W-1:0];
                CFG_LEFT_READY:      cfg_reg.left_ready      <= cfg_wdata[0];
                CFG_RIGHT_READY:     cfg_reg.right_ready     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dmssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_free  (out_free),
        .res_load  (res_load),
        .running   (running),
        .ramping   (ramping),
        .accepted  (accepted),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    dmssp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .in_action     (s_axis_tuser[0]),
        .in_left       (s_axis_tdata[15:0]),
        .in_right      (s_axis_tdata[31:16]),
        .left_forward  (left_forward),
        .left_duty     (left_duty),
        .right_forward (right_forward),
        .right_duty    (right_duty)
    );

    // result register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_data_reg <= {3'b000, accepted, ramping, running,
                             right_duty, right_forward, left_duty, left_forward};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ design/dmssp_dp.sv @@
// Datapath: speed operands, shared multiplier, duty mapping and pin output registers.
`default_nettype none

module dmssp_dp
    import dmssp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic                      in_action,
    input  logic signed [SPEED_W-1:0] in_left,
    input  logic signed [SPEED_W-1:0] in_right,
    output logic                      left_forward,
    output logic [DUTY_W-1:0]         left_duty,
    output logic                      right_forward,
    output logic [DUTY_W-1:0]         right_duty
);

    // magnitude with -1.0 clamped to the largest positive code
    function automatic logic [MAG_W-1:0] mag_of(input logic [SPEED_W-1:0] raw);
        logic [SPEED_W-1:0] neg;
        neg = SPEED_W'(~raw + 1'b1);
        if (!raw[SPEED_W-1])
            return raw[MAG_W-1:0];
        else if (neg[SPEED_W-1])
            return {MAG_W{1'b1}};
        else
            return neg[MAG_W-1:0];
    endfunction

    logic               action_reg;
    logic [MAG_W-1:0]   item_l_mag_reg, item_r_mag_reg;
    logic               item_l_neg_reg, item_r_neg_reg;
    logic [MAG_W-1:0]   held_l_mag_reg, held_r_mag_reg;
    logic               held_l_neg_reg, held_r_neg_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               neg_reg, stop_reg, fwd_reg;
    logic               left_fwd_reg, right_fwd_reg;
    logic [DUTY_W-1:0]  left_duty_reg, right_duty_reg;

    logic [MAG_W-1:0]    src_mag;
    logic                src_neg;
    logic [FACTOR_W-1:0] factor;
    logic [MAG_W-1:0]    mul_a;
    logic [FACTOR_W-1:0] mul_b;
    logic [PROD_W-1:0]   rounded;
    logic [MAG_W-1:0]    mag2;
    logic [BITS_W-1:0]   bits_eff;
    logic [SCALE_W-1:0]  scale_eff;
    logic [DUTY_W:0]     full17;
    logic [DUTY_W-1:0]   full_duty;
    logic [39:0]         duty_sum;
    logic [16:0]         duty_raw;
    logic [DUTY_W-1:0]   duty_w;
    logic                fwd_w;

    always_comb
    begin
        case (cmd.src)
            SRC_ITEM_L:
            begin
                src_mag = item_l_mag_reg;
                src_neg = item_l_neg_reg;
            end
            SRC_ITEM_R:
            begin
                src_mag = item_r_mag_reg;
                src_neg = item_r_neg_reg;
            end
            SRC_HELD_L:
            begin
                src_mag = held_l_mag_reg;
                src_neg = held_l_neg_reg;
            end
            SRC_HELD_R:
            begin
                src_mag = held_r_mag_reg;
                src_neg = held_r_neg_reg;
            end
            default:
            begin
                src_mag = '0;
                src_neg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.fac)
            FAC_LOW: factor = FACTOR_LOW;
            FAC_MID: factor = FACTOR_MID;
            default: factor = FACTOR_ONE;
        endcase
    end

    assign bits_eff  = (cfg.pwm_bits < BITS_MIN) ? BITS_MIN :
                       ((cfg.pwm_bits > BITS_MAX) ? BITS_MAX : cfg.pwm_bits);
    assign scale_eff = (cfg.output_scale > SCALE_MAX) ? SCALE_MAX : cfg.output_scale;
    assign full17    = (17'd1 << bits_eff) - 17'd1;
    assign full_duty = full17[DUTY_W-1:0];

    // round half up of mag * factor / 2^15
    assign rounded = prod_reg + PROD_W'(16384);
    assign mag2    = rounded[29:15];

    // one shared multiplier: ramp factor first, then output scale
    assign mul_a     = cmd.mul_scale ? mag2 : src_mag;
    assign mul_b     = cmd.mul_scale ? FACTOR_W'(scale_eff) : factor;
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // p * (2^bits - 1) as a shift and subtract, rounded, divided by 2^23
    assign duty_sum = (40'(prod_reg[23:0]) << bits_eff) - 40'(prod_reg[23:0])
                      + 40'h40_0000;
    assign duty_raw = duty_sum[39:23];
    assign duty_w   = stop_reg ? '0 :
                      ((duty_raw > {1'b0, full_duty}) ? full_duty : duty_raw[DUTY_W-1:0]);
    assign fwd_w    = stop_reg ? 1'b0 : fwd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg     <= in_action;
            item_l_mag_reg <= mag_of(in_left);
            item_l_neg_reg <= in_left[SPEED_W-1];
            item_r_mag_reg <= mag_of(in_right);
            item_r_neg_reg <= in_right[SPEED_W-1];
        end
        if (cmd.mul_factor)
        begin
            prod_reg <= prod_next;
            neg_reg  <= src_neg;
        end
        if (cmd.mul_scale)
        begin
            prod_reg <= prod_next;
            stop_reg <= (mag2 < STOP_LIMIT);
            fwd_reg  <= !neg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_l_mag_reg <= '0;
            held_l_neg_reg <= 1'b0;
            held_r_mag_reg <= '0;
            held_r_neg_reg <= 1'b0;
            left_fwd_reg   <= 1'b0;
            left_duty_reg  <= '0;
            right_fwd_reg  <= 1'b0;
            right_duty_reg <= '0;
        end
        else
        begin
            if (cmd.hold_targets)
            begin
                held_l_mag_reg <= item_l_mag_reg;
                held_l_neg_reg <= item_l_neg_reg;
                held_r_mag_reg <= item_r_mag_reg;
                held_r_neg_reg <= item_r_neg_reg;
            end
            if (cmd.write_left && cfg.left_ready)
            begin
                left_fwd_reg  <= fwd_w;
                left_duty_reg <= duty_w;
            end
            if (cmd.write_right && cfg.right_ready)
            begin
                right_fwd_reg  <= fwd_w;
                right_duty_reg <= duty_w;
            end
        end
    end

    assign status.action     = action_reg;
    assign status.item_small = (item_l_mag_reg < START_LIMIT) &&
                               (item_r_mag_reg < START_LIMIT);

    assign left_forward  = left_fwd_reg;
    assign left_duty     = left_duty_reg;
    assign right_forward = right_fwd_reg;
    assign right_duty    = right_duty_reg;

endmodule

`default_nettype wire

@@ design/dmssp_ctrl.sv @@
// Controller: item sequencing, soft start stages, tick timer and started flag.
`default_nettype none
`include "dual_motor_soft_start_pwm_defines.svh"

module dmssp_ctrl
    import dmssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    output logic       res_load,
    output logic       running,
    output logic       ramping,
    output logic       accepted,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_L_MULF = 4'd2;
    localparam logic [3:0] ST_L_MULS = 4'd3;
    localparam logic [3:0] ST_L_WR   = 4'd4;
    localparam logic [3:0] ST_R_MULF = 4'd5;
    localparam logic [3:0] ST_R_MULS = 4'd6;
    localparam logic [3:0] ST_R_WR   = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_L_LOW = 3'd1;
    localparam logic [2:0] STAGE_L_MID = 3'd2;
    localparam logic [2:0] STAGE_GAP   = 3'd3;
    localparam logic [2:0] STAGE_R_LOW = 3'd4;
    localparam logic [2:0] STAGE_R_MID = 3'd5;

    localparam logic [2:0] PLAN_BOTH   = 3'd0;
    localparam logic [2:0] PLAN_START  = 3'd1;
    localparam logic [2:0] PLAN_L_MID  = 3'd2;
    localparam logic [2:0] PLAN_L_FULL = 3'd3;
    localparam logic [2:0] PLAN_R_LOW  = 3'd4;
    localparam logic [2:0] PLAN_R_MID  = 3'd5;
    localparam logic [2:0] PLAN_R_FULL = 3'd6;

    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    logic [3:0]                 state_reg, state_next;
    logic [2:0]                 plan_reg, plan_next;
    logic [2:0]                 stage_reg, stage_next;
    logic [TICK_COUNT_BITS-1:0] wait_reg, wait_next;
    logic                       started_reg, started_next;
    logic                       acc_reg, acc_next;

    logic [TICK_COUNT_BITS-1:0] wait_inc;
    logic [TICKS_W-1:0]         ticks_sel, ticks_lim;
    logic                       lim_hit;
    logic                       hold_w;
    logic [2:0]                 left_src, right_src;
    logic [1:0]                 left_fac, right_fac;

    // stage timer: saturating count, zero ticks act as one
    assign wait_inc  = (wait_reg == TICK_MAX) ? wait_reg
                                              : wait_reg + TICK_COUNT_BITS'(1);
    assign ticks_sel = (stage_reg == STAGE_GAP) ? cfg.motor_gap_ticks : cfg.ramp_step_ticks;
    assign ticks_lim = (ticks_sel == '0) ? TICKS_W'(1) : ticks_sel;
    assign lim_hit   = (TICK_CMP_W'(wait_inc) >= TICK_CMP_W'(ticks_lim)) ||
                       (wait_inc == TICK_MAX);

    // operand selection per channel
    always_comb
    begin
        left_src  = SRC_ITEM_L;
        left_fac  = FAC_ONE;
        right_src = SRC_ITEM_R;
        right_fac = FAC_ONE;
        case (plan_reg)
            PLAN_START:
            begin
                left_fac  = FAC_LOW;
                right_src = SRC_ZERO;
            end
            PLAN_L_MID:
            begin
                left_src = SRC_HELD_L;
                left_fac = FAC_MID;
            end
            PLAN_L_FULL: left_src = SRC_HELD_L;
            PLAN_R_LOW:
            begin
                right_src = SRC_HELD_R;
                right_fac = FAC_LOW;
            end
            PLAN_R_MID:
            begin
                right_src = SRC_HELD_R;
                right_fac = FAC_MID;
            end
            PLAN_R_FULL: right_src = SRC_HELD_R;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        plan_next    = plan_reg;
        stage_next   = stage_reg;
        wait_next    = wait_reg;
        started_next = started_reg;
        acc_next     = acc_reg;
        hold_w       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                acc_next = 1'b1;
                if (dp_status.action == ACTION_CMD)
                begin
                    if (stage_reg != STAGE_IDLE)
                    begin
                        // ignored while the soft start runs
                        acc_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_L_MULF;
                        plan_next  = PLAN_BOTH;
                        if (dp_status.item_small)
                            started_next = 1'b0;
                        else if (started_reg)
                            started_next = 1'b1;
                        else if (!cfg.left_ready || !cfg.right_ready)
                            started_next = 1'b1;
                        else
                        begin
                            plan_next  = PLAN_START;
                            hold_w     = 1'b1;
                            stage_next = STAGE_L_LOW;
                            wait_next  = '0;
                        end
                    end
                end
                else if (stage_reg != STAGE_IDLE)
                begin
                    if (lim_hit)
                    begin
                        wait_next = '0;
                        case (stage_reg)
                            STAGE_L_LOW:
                            begin
                                plan_next  = PLAN_L_MID;
                                stage_next = STAGE_L_MID;
                                state_next = ST_L_MULF;
                            end
                            STAGE_L_MID:
                            begin
                                plan_next  = PLAN_L_FULL;
                                stage_next = STAGE_GAP;
                                state_next = ST_L_MULF;
                            end
                            STAGE_GAP:
                            begin
                                plan_next  = PLAN_R_LOW;
                                stage_next = STAGE_R_LOW;
                                state_next = ST_R_MULF;
                            end
                            STAGE_R_LOW:
                            begin
                                plan_next  = PLAN_R_MID;
                                stage_next = STAGE_R_MID;
                                state_next = ST_R_MULF;
                            end
                            default:
                            begin
                                plan_next    = PLAN_R_FULL;
                                stage_next   = STAGE_IDLE;
                                started_next = 1'b1;
                                state_next   = ST_R_MULF;
                            end
                        endcase
                    end
                    else
                    begin
                        wait_next  = wait_inc;
                        state_next = ST_FIN;
                    end
                end
                else
                    state_next = ST_FIN;
            end
            ST_L_MULF: state_next = ST_L_MULS;
            ST_L_MULS: state_next = ST_L_WR;
            ST_L_WR:
            begin
                if (plan_reg inside {PLAN_BOTH, PLAN_START})
                    state_next = ST_R_MULF;
                else
                    state_next = ST_FIN;
            end
            ST_R_MULF: state_next = ST_R_MULS;
            ST_R_MULS: state_next = ST_R_WR;
            ST_R_WR:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            plan_reg    <= PLAN_BOTH;
            stage_reg   <= STAGE_IDLE;
            wait_reg    <= '0;
            started_reg <= 1'b0;
            acc_reg     <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            plan_reg    <= plan_next;
            stage_reg   <= stage_next;
            wait_reg    <= wait_next;
            started_reg <= started_next;
            acc_reg     <= acc_next;
        end
    end

    always_comb
    begin
        dp_cmd              = '0;
        dp_cmd.load_item    = (state_reg == ST_IDLE) && in_valid;
        dp_cmd.hold_targets = hold_w;
        case (state_reg)
            ST_L_MULF:
            begin
                dp_cmd.mul_factor = 1'b1;
                dp_cmd.src        = left_src;
                dp_cmd.fac        = left_fac;
            end
            ST_R_MULF:
            begin
                dp_cmd.mul_factor = 1'b1;
                dp_cmd.src        = right_src;
                dp_cmd.fac        = right_fac;
            end
            ST_L_MULS, ST_R_MULS: dp_cmd.mul_scale = 1'b1;
            ST_L_WR:   dp_cmd.write_left  = 1'b1;
            ST_R_WR:   dp_cmd.write_right = 1'b1;
            default: ;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign res_load = (state_reg == ST_FIN) && out_free;
    assign running  = started_reg;
    assign ramping  = (stage_reg != STAGE_IDLE);
    assign accepted = acc_reg;

    // the ramp only starts from the stopped state and commands cannot restart it
    `DMSSP_ASSERT_HOLDS(a_ramp_not_started, clk, rst_n, stage_reg != STAGE_IDLE,
        !started_reg, "started flag set during soft start")
    // the stage timer is parked at zero outside the ramp
    `DMSSP_ASSERT_HOLDS(a_wait_idle_zero, clk, rst_n, stage_reg == STAGE_IDLE,
        wait_reg == '0, "stage timer running outside soft start")
    // stages only advance by one or finish
    `DMSSP_ASSERT_NEXT(a_stage_step, clk, rst_n, stage_reg != STAGE_IDLE,
        stage_reg == $past(stage_reg) || stage_reg == $past(stage_reg) + 3'd1 || stage_reg == STAGE_IDLE,
        "soft start stage skipped")
    // a command seen mid-ramp never touches the pin outputs
    `DMSSP_ASSERT_NEXT(a_ignored_no_drive, clk, rst_n,
        state_reg == ST_DECIDE && dp_status.action == ACTION_CMD && stage_reg != STAGE_IDLE,
        state_reg == ST_FIN && !acc_reg, "command during soft start was applied")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the dual motor soft start PWM block.
`timescale 1ns / 1ps

import dmssp_pkg::*;

// soft start wait stages, named after what the outputs hold while waiting
typedef enum int {
    RAMP_IDLE,
    LEFT_LOW,
    LEFT_MID,
    GAP_WAIT,
    RIGHT_LOW,
    RIGHT_MID
} ramp_phase_t;

// one result word as it sits on m_axis_tdata, lowest field last
typedef struct packed {
    logic [2:0]        pad;
    logic              accepted;
    logic              ramping;
    logic              running;
    logic [DUTY_W-1:0] right_duty;
    logic              right_forward;
    logic [DUTY_W-1:0] left_duty;
    logic              left_forward;
} pin_word_t;

typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] duty;
} channel_t;

// Scoreboard: mirrors the driver state and holds the pin words still owed.
class motor_scoreboard;
    cfg_t            regs;
    ramp_phase_t     stage;
    longint unsigned wait_ticks;
    int              held_left;
    int              held_right;
    bit              running;
    channel_t        left_ch;
    channel_t        right_ch;
    pin_word_t       expected_pins[$];
    int              errors;
    int              commands;
    int              ticks;
    int              ramps;
    int              dropped;

    localparam longint unsigned TICK_MAX = (64'd1 << TICK_COUNT_BITS) - 1;

    function new();
        regs.pwm_bits        = 5'd10;
        regs.output_scale    = 9'd179;
        regs.ramp_step_ticks = 16'd30;
        regs.motor_gap_ticks = 16'd60;
        regs.left_ready      = 1'b0;
        regs.right_ready     = 1'b0;
        stage      = RAMP_IDLE;
        wait_ticks = 0;
        held_left  = 0;
        held_right = 0;
        running    = 1'b0;
        left_ch    = '0;
        right_ch   = '0;
    endfunction

    // -32768 has no positive twin, so it clamps to -32767
    function int speed_value(logic [SPEED_W-1:0] raw);
        int v;
        v = int'($signed(raw));
        if (v < -32767)
            v = -32767;
        return v;
    endfunction

    // Q15 factor, rounded half away from zero
    function int ramp_fraction(int q, int unsigned f);
        int unsigned mag;
        int unsigned r;
        mag = q < 0 ? -q : q;
        r = (mag * f + 32'd16384) >> 15;
        return q < 0 ? -int'(r) : int'(r);
    endfunction

    function channel_t channel_level(int q);
        channel_t        ch;
        int unsigned     mag;
        int unsigned     bits;
        longint unsigned full;
        longint unsigned sc;
        longint unsigned d;
        mag  = q < 0 ? -q : q;
        bits = 32'(regs.pwm_bits < BITS_MIN ? BITS_MIN :
                    (regs.pwm_bits > BITS_MAX ? BITS_MAX : regs.pwm_bits));
        full = (64'd1 << bits) - 1;
        sc   = 64'(regs.output_scale > SCALE_MAX ? SCALE_MAX : regs.output_scale);
        ch   = '0;
        if (mag < STOP_LIMIT)
            return ch;
        ch.fwd = q > 0;
        d = (longint'(mag) * full * sc + (64'd1 << 22)) >> 23;
        if (d > full)
            d = full;
        ch.duty = d[DUTY_W-1:0];
        return ch;
    endfunction

    // a channel that is not ready keeps its pins
    function void drive_left(int q);
        if (regs.left_ready)
            left_ch = channel_level(q);
    endfunction

    function void drive_right(int q);
        if (regs.right_ready)
            right_ch = channel_level(q);
    endfunction

    // advance the mirror by one accepted word and queue the pin word it must give
    function void predict_word(logic act, logic [SPEED_W-1:0] left_raw,
                               logic [SPEED_W-1:0] right_raw);
        int              l;
        int              r;
        logic            taken;
        longint unsigned limit;
        pin_word_t       w;
        taken = 1'b1;
        if (act == ACTION_CMD)
        begin
            commands++;
            l = speed_value(left_raw);
            r = speed_value(right_raw);
            if (stage != RAMP_IDLE)
            begin
                taken = 1'b0;
                dropped++;
            end
            else if ((l < 0 ? -l : l) < START_LIMIT && (r < 0 ? -r : r) < START_LIMIT)
            begin
                drive_left(l);
                drive_right(r);
                running = 1'b0;
            end
            else if (running || !regs.left_ready || !regs.right_ready)
            begin
                drive_left(l);
                drive_right(r);
                running = 1'b1;
            end
            else
            begin
                held_left  = l;
                held_right = r;
                drive_left(ramp_fraction(l, FACTOR_LOW));
                drive_right(0);
                stage      = LEFT_LOW;
                wait_ticks = 0;
                ramps++;
            end
        end
        else
        begin
            ticks++;
            if (stage != RAMP_IDLE)
            begin
                limit = 64'(stage == GAP_WAIT ? regs.motor_gap_ticks : regs.ramp_step_ticks);
                if (limit == 0)
                    limit = 1;
                if (limit > TICK_MAX)
                    limit = TICK_MAX;
                if (wait_ticks < TICK_MAX)
                    wait_ticks++;
                if (wait_ticks >= limit)
                begin
                    wait_ticks = 0;
                    case (stage)
                        LEFT_LOW:
                        begin
                            drive_left(ramp_fraction(held_left, FACTOR_MID));
                            stage = LEFT_MID;
                        end
                        LEFT_MID:
                        begin
                            drive_left(held_left);
                            stage = GAP_WAIT;
                        end
                        GAP_WAIT:
                        begin
                            drive_right(ramp_fraction(held_right, FACTOR_LOW));
                            stage = RIGHT_LOW;
                        end
                        RIGHT_LOW:
                        begin
                            drive_right(ramp_fraction(held_right, FACTOR_MID));
                            stage = RIGHT_MID;
                        end
                        default:
                        begin
                            drive_right(held_right);
                            stage   = RAMP_IDLE;
                            running = 1'b1;
                        end
                    endcase
                end
            end
        end
        w               = '0;
        w.left_forward  = left_ch.fwd;
        w.left_duty     = left_ch.duty;
        w.right_forward = right_ch.fwd;
        w.right_duty    = right_ch.duty;
        w.running       = running;
        w.ramping       = stage != RAMP_IDLE;
        w.accepted      = taken;
        expected_pins.push_back(w);
    endfunction

    function void compare(string field, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function void check_pins(logic [39:0] data);
        pin_word_t got;
        pin_word_t want;
        got = data;
        if (expected_pins.size() == 0)
        begin
            errors++;
            $display("%0t: result word expected none, got %h", $time, data);
            return;
        end
        want = expected_pins.pop_front();
        compare("left_forward", want.left_forward, got.left_forward);
        compare("left_duty", want.left_duty, got.left_duty);
        compare("right_forward", want.right_forward, got.right_forward);
        compare("right_duty", want.right_duty, got.right_duty);
        compare("running", want.running, got.running);
        compare("ramping", want.ramping, got.ramping);
        compare("accepted", want.accepted, got.accepted);
        compare("pad bits", want.pad, got.pad);
    endfunction

    function int outstanding();
        return expected_pins.size();
    endfunction
endclass

module tb;

    // covers the slowest word's path from acceptance to result, with margin on top
    localparam int LATENCY     = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 150;

    // indexes past the register map; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;   // [15:0] left_speed, [31:16] right_speed
    logic [0:0]            s_axis_tuser  = '0;   // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] left_forward, [16:1] left_duty, [17] right_forward, [33:18] right_duty,
    // [34] running, [35] ramping, [36] accepted, [39:37] zero
    logic [39:0]           m_axis_tdata;

    motor_scoreboard sb = new();
    bit              no_idle = 1'b0;   // set for the stretch without any idling
    int              cycle_count = 0;
    int              settings_count = 0;

    dual_motor_soft_start_pwm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check every accepted word, stall at random with a chance of 0.19 unless no_idle is set
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pins(m_axis_tdata);
        m_axis_tready <= no_idle || ($urandom_range(99) >= 19);
    end

    // one register write per edge; the caller drops cfg_we after the last one
    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Program all six registers and one unmapped index; bits above each register's width
    // carry noise and must be dropped by the block.
    task automatic apply_settings(input cfg_t c);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        put_reg(CFG_PWM_BITS, {noise[15:5], c.pwm_bits});
        put_reg(CFG_OUTPUT_SCALE, {noise[15:9], c.output_scale});
        put_reg(CFG_RAMP_STEP_TICKS, c.ramp_step_ticks);
        put_reg(CFG_MOTOR_GAP_TICKS, c.motor_gap_ticks);
        put_reg(CFG_LEFT_READY, {noise[15:1], c.left_ready});
        put_reg(CFG_RIGHT_READY, {noise[14:0], c.right_ready});
        put_reg($urandom_range(1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, CFG_DATA_W'($urandom));
        cfg_we  <= 1'b0;
        sb.regs = c;
        settings_count++;
    endtask

    // Present one input word, wait for the handshake, then predict its result.
    task automatic send_word(input logic act, input logic [SPEED_W-1:0] left_raw,
                             input logic [SPEED_W-1:0] right_raw);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_raw, left_raw};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.predict_word(act, left_raw, right_raw);
    endtask

    // stop sending, let every owed result drain, then give the block time to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // speeds weighted toward the clamp, stop and start thresholds
    function automatic logic [SPEED_W-1:0] pick_speed();
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(7))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 32;
                3:       v = 33;
                4:       v = 655;
                5:       v = 656;
                6:       v = 1;
                default: v = 0;
            endcase
            if ($urandom_range(1))
                v = -v;
        end
        else if (pick < 45)
            v = $urandom_range(1) ? int'($urandom_range(700)) : -int'($urandom_range(700));
        else
            v = $urandom;
        return v[SPEED_W-1:0];
    endfunction

    // speeds of magnitude up to 660, mostly under the start limit, so a pair of them usually clears running
    function automatic logic [SPEED_W-1:0] stop_speed();
        int v;
        v = $urandom_range(660);
        return $urandom_range(1) ? v[SPEED_W-1:0] : -v[SPEED_W-1:0];
    endfunction

    // Mostly ticks so soft starts run to completion, with commands mixed in; ticks
    // carry random speed bits that the block must ignore.
    task automatic random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_word(ACTION_TICK, SPEED_W'($urandom), SPEED_W'($urandom));
        else if (pick < 67)
            send_word(ACTION_CMD, stop_speed(), stop_speed());
        else
            send_word(ACTION_CMD, pick_speed(), pick_speed());
    endtask

    // register settings per random phase; the first few pin the extremes
    function automatic cfg_t phase_settings(int k);
        cfg_t c;
        c.pwm_bits        = BITS_W'($urandom_range(1, 16));
        c.output_scale    = SCALE_W'($urandom_range(128, 256));
        c.ramp_step_ticks = TICKS_W'($urandom_range(0, 4));
        c.motor_gap_ticks = TICKS_W'($urandom_range(0, 8));
        c.left_ready      = 1'b1;
        c.right_ready     = 1'b1;
        if ($urandom_range(9) == 0)
            c.pwm_bits = BITS_W'($urandom);
        if ($urandom_range(4) == 0)
            c.output_scale = SCALE_W'($urandom);
        case (k)
            0:
            begin
                c.pwm_bits     = 5'd16;
                c.output_scale = 9'd256;
            end
            1:
            begin
                c.pwm_bits     = 5'd1;
                c.output_scale = 9'd1;
            end
            2:
            begin
                c.pwm_bits     = 5'd0;
                c.output_scale = 9'd511;
            end
            3:
            begin
                c.pwm_bits     = 5'd31;
                c.output_scale = 9'd257;
            end
            4:
            begin
                // ramp stalls here; the next phase shortens it mid-ramp
                c.ramp_step_ticks = 16'hFFFF;
                c.motor_gap_ticks = 16'hFFFF;
            end
            5:
            begin
                c.ramp_step_ticks = 16'd0;
                c.motor_gap_ticks = 16'd0;
            end
            6:
            begin
                c.output_scale = 9'd0;
                c.right_ready  = 1'b0;
            end
            7:       c.left_ready = 1'b0;
            8:
            begin
                c.left_ready  = 1'b0;
                c.right_ready = 1'b0;
            end
            default: ;
        endcase
        return c;
    endfunction

    initial
    begin
        cfg_t c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: neither channel ready
        send_word(ACTION_TICK, 16'h0000, 16'h0000);     // tick while idle
        send_word(ACTION_CMD, 16'd12000, -16'sd12000);  // no ramp, running set, pins kept
        drain();

        // full resolution, unity scale, zero step ticks acting as one, short gap
        c.pwm_bits        = 5'd16;
        c.output_scale    = 9'd256;
        c.ramp_step_ticks = 16'd0;
        c.motor_gap_ticks = 16'd2;
        c.left_ready      = 1'b1;
        c.right_ready     = 1'b1;
        apply_settings(c);
        send_word(ACTION_CMD, 16'h0000, 16'h0000);      // stop, clears running
        send_word(ACTION_CMD, 16'h8000, 16'h7FFF);      // most negative clamps, ramp starts
        send_word(ACTION_CMD, 16'd100, -16'sd100);      // dropped during ramp
        repeat (6) send_word(ACTION_TICK, 16'hFFFF, 16'hFFFF);  // walk the whole ramp
        send_word(ACTION_CMD, 16'd32, -16'sd33);        // stop threshold both sides
        send_word(ACTION_CMD, 16'd655, -16'sd656);      // just over the start limit
        repeat (6) send_word(ACTION_TICK, 16'h0000, 16'h0000);
        send_word(ACTION_CMD, -16'sd20000, 16'd1);      // running: applied directly
        send_word(ACTION_TICK, 16'h5555, 16'hAAAA);     // tick while idle
        send_word(ACTION_CMD, 16'h8001, 16'd33);
        drain();

        // resolution and scale out of range, right channel not ready
        c.pwm_bits        = 5'd0;
        c.output_scale    = 9'd511;
        c.ramp_step_ticks = 16'd1;
        c.motor_gap_ticks = 16'd1;
        c.left_ready      = 1'b1;
        c.right_ready     = 1'b0;
        apply_settings(c);
        send_word(ACTION_CMD, 16'h0000, 16'h0000);
        send_word(ACTION_CMD, 16'h7FFF, 16'h8001);      // start with one channel: no ramp
        send_word(ACTION_CMD, 16'd1000, 16'd1000);
        drain();

        // random phases; one of them runs with no idling on either side
        for (int k = 0; k < PHASES; k++)
        begin
            apply_settings(phase_settings(k));
            no_idle <= (k == 3);
            @(posedge clk);
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
            drain();
        end

        $display("covered %0d command words (%0d dropped) and %0d ticks, %0d soft starts,",
                 sb.commands, sb.dropped, sb.ticks, sb.ramps);
        $display("under %0d register settings; %0d mismatches", settings_count, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
